// ----- hdl/point_to_scan_bin_projector_defines.svh -----
// ----------------------------------------------------------------------------
// Point to scan bin projector assertion macros
// Shared assertion forms for the checker of the projector.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_SCAN_BIN_PROJECTOR_DEFINES_SVH
`define POINT_TO_SCAN_BIN_PROJECTOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define PBP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PBP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/pbp_pkg.sv -----
// ----------------------------------------------------------------------------
// pbp_pkg
// Types and constants shared by the point to scan bin projector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbp_pkg;

   // Point kinds.
   localparam logic [1:0] KIND_SERVICE  = 2'd0;
   localparam logic [1:0] KIND_NARROW   = 2'd1;
   localparam logic [1:0] KIND_WIDE     = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_SERVICE_ENABLE    = 2'd0;
   localparam logic [1:0] REG_SERVICE_RADIUS_SQ = 2'd1;
   localparam logic [1:0] REG_BLOCK_RADIUS_SQ   = 2'd2;
   localparam logic [1:0] REG_WIDE_RANGE_OFFSET = 2'd3;

   // Datapath widths.
   localparam int CX_W       = 44;
   localparam int Z_W        = 29;
   localparam int ANG_W      = 30;
   localparam int SQRT_STEPS = 16;

   // Angles are in units of 2^-24 rad.
   localparam logic signed [ANG_W-1:0] ANG_PI    = 30'sd52707179;
   localparam logic signed [ANG_W-1:0] ANG_TWOPI = 30'sd105414358;

   // One bin is 0.007 rad, that is 7 * 2^24 / 1000 angle units.
   localparam logic [9:0]  BIN_NUM   = 10'd1000;
   localparam int          BIN_SHIFT = 24;
   localparam logic [13:0] RECIP7    = 14'd9362;
   localparam int          RECIP7_SH = 16;

   localparam logic [23:0] ATAN_TAB [24] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
      24'd1047214,  24'd524117,  24'd262123,  24'd131069,
      24'd65536,    24'd32768,   24'd16384,   24'd8192,
      24'd4096,     24'd2048,    24'd1024,    24'd512,
      24'd256,      24'd128,     24'd64,      24'd32,
      24'd16,       24'd8,       24'd4,       24'd2
   };

   typedef struct packed {
      logic signed [23:0] robot_x;
      logic signed [23:0] robot_y;
      logic signed [15:0] robot_yaw;
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic [1:0]         point_kind;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [9:0]  center_bin;
      logic [3:0]  half_width;
      logic [15:0] range_value;
   } rsp_type;

   // Control that travels with an item through the pipeline.
   typedef struct packed {
      logic               valid;
      logic               keep;
      logic [1:0]         kind;
      logic signed [15:0] yaw;
   } tag_type;

endpackage

`default_nettype wire

// ----- hdl/pbp_front.sv -----
// ----------------------------------------------------------------------------
// pbp_front
// Offsets, squared distance, radius test and rotation start values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbp_front import pbp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire req_type                 req,
   input  wire logic                    service_enable,
   input  wire logic [15:0]             service_radius_sq,
   input  wire logic [15:0]             block_radius_sq,
   output tag_type                      out_tag,
   output logic signed [CX_W-1:0]       out_cx,
   output logic signed [CX_W-1:0]       out_cy,
   output logic signed [Z_W-1:0]        out_z,
   output logic [31:0]                  out_rad
);

   // Stage A: offsets.
   logic               a_valid_ff;
   logic [1:0]         a_kind_ff;
   logic signed [15:0] a_yaw_ff;
   logic signed [24:0] a_dx_ff, a_dy_ff;

   always_ff @(posedge clock) begin
      a_dx_ff   <= 25'(req.point_x) - 25'(req.robot_x);
      a_dy_ff   <= 25'(req.point_y) - 25'(req.robot_y);
      a_kind_ff <= req.point_kind;
      a_yaw_ff  <= req.robot_yaw;
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   // Stage B: squares.
   logic               b_valid_ff;
   logic [1:0]         b_kind_ff;
   logic signed [15:0] b_yaw_ff;
   logic signed [24:0] b_dx_ff, b_dy_ff;
   logic signed [49:0] b_dx2_ff, b_dy2_ff;

   always_ff @(posedge clock) begin
      b_dx2_ff <= a_dx_ff * a_dx_ff;
      b_dy2_ff <= a_dy_ff * a_dy_ff;
      // A zero x offset counts as one LSB for the bearing only.
      b_dx_ff  <= (a_dx_ff == 25'sd0) ? 25'sd1 : a_dx_ff;
      b_dy_ff  <= a_dy_ff;
      b_kind_ff <= a_kind_ff;
      b_yaw_ff  <= a_yaw_ff;
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   // Stage C: radius test and rotation start.
   logic [50:0]           dist_sum;
   logic [15:0]           radius;
   logic                  keep_in;
   logic signed [CX_W-1:0] dxw, dyw, cx_in, cy_in;
   logic signed [Z_W-1:0]  z_in;

   always_comb begin
      dist_sum = 51'($unsigned(b_dx2_ff)) + 51'($unsigned(b_dy2_ff));
      radius   = (b_kind_ff == KIND_SERVICE) ? service_radius_sq : block_radius_sq;
      keep_in  = (dist_sum <= 51'({radius, 16'h0000}))
               && (b_kind_ff == KIND_SERVICE || b_kind_ff == KIND_NARROW
                   || b_kind_ff == KIND_WIDE)
               && !(b_kind_ff == KIND_SERVICE && !service_enable);
      dxw = CX_W'(b_dx_ff);
      dyw = CX_W'(b_dy_ff);
      // A negative x offset is turned over by pi so the rotation converges.
      if (b_dx_ff < 25'sd0) begin
         cx_in = (-dxw) <<< 16;
         cy_in = (-dyw) <<< 16;
         z_in  = (b_dy_ff >= 25'sd0) ? Z_W'(ANG_PI) : Z_W'(-ANG_PI);
      end else begin
         cx_in = dxw <<< 16;
         cy_in = dyw <<< 16;
         z_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      out_tag.keep <= keep_in;
      out_tag.kind <= b_kind_ff;
      out_tag.yaw  <= b_yaw_ff;
      out_cx       <= cx_in;
      out_cy       <= cy_in;
      out_z        <= z_in;
      out_rad      <= dist_sum[31:0];
      if (reset) begin
         out_tag.valid <= 1'b0;
      end else begin
         out_tag.valid <= b_valid_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/pbp_iter.sv -----
// ----------------------------------------------------------------------------
// pbp_iter
// Pipelined CORDIC vectoring and square root, one step per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbp_iter import pbp_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tag_type                 in_tag,
   input  wire logic signed [CX_W-1:0]  in_cx,
   input  wire logic signed [CX_W-1:0]  in_cy,
   input  wire logic signed [Z_W-1:0]   in_z,
   input  wire logic [31:0]             in_rad,
   output tag_type                      out_tag,
   output logic signed [Z_W-1:0]        out_z,
   output logic [15:0]                  out_root
);

   localparam int LEN = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

   tag_type                tag_ff  [LEN];
   logic signed [CX_W-1:0] cx_ff   [LEN];
   logic signed [CX_W-1:0] cy_ff   [LEN];
   logic signed [Z_W-1:0]  z_ff    [LEN];
   logic [17:0]            rem_ff  [LEN];
   logic [15:0]            root_ff [LEN];
   logic [31:0]            rad_ff  [LEN];

   for (genvar i = 0; i < LEN; i++) begin : g_stage
      tag_type                tag_src;
      logic signed [CX_W-1:0] cx_src, cy_src, cx_in, cy_in;
      logic signed [Z_W-1:0]  z_src, z_in;
      logic [17:0]            rem_src, rem_in;
      logic [15:0]            root_src, root_in;
      logic [31:0]            rad_src, rad_in;

      if (i == 0) begin : g_first
         assign tag_src  = in_tag;
         assign cx_src   = in_cx;
         assign cy_src   = in_cy;
         assign z_src    = in_z;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_rad;
      end else begin : g_next
         assign tag_src  = tag_ff[i-1];
         assign cx_src   = cx_ff[i-1];
         assign cy_src   = cy_ff[i-1];
         assign z_src    = z_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign rad_src  = rad_ff[i-1];
      end

      if (i < CORDIC_STAGES) begin : g_rot
         always_comb begin
            if (cy_src >= 0) begin
               cx_in = cx_src + (cy_src >>> i);
               cy_in = cy_src - (cx_src >>> i);
               z_in  = z_src + $signed(Z_W'(ATAN_TAB[i]));
            end else begin
               cx_in = cx_src - (cy_src >>> i);
               cy_in = cy_src + (cx_src >>> i);
               z_in  = z_src - $signed(Z_W'(ATAN_TAB[i]));
            end
         end
      end else begin : g_rot_pass
         assign cx_in = cx_src;
         assign cy_in = cy_src;
         assign z_in  = z_src;
      end

      if (i < SQRT_STEPS) begin : g_root
         logic [19:0] rem_sh, trial;
         always_comb begin
            rem_sh = {rem_src, rad_src[31:30]};
            trial  = {2'b00, root_src, 2'b01};
            rad_in = rad_src << 2;
            if (rem_sh >= trial) begin
               rem_in  = 18'(rem_sh - trial);
               root_in = {root_src[14:0], 1'b1};
            end else begin
               rem_in  = 18'(rem_sh);
               root_in = {root_src[14:0], 1'b0};
            end
         end
      end else begin : g_root_pass
         assign rem_in  = rem_src;
         assign root_in = root_src;
         assign rad_in  = rad_src;
      end

      always_ff @(posedge clock) begin
         tag_ff[i].keep <= tag_src.keep;
         tag_ff[i].kind <= tag_src.kind;
         tag_ff[i].yaw  <= tag_src.yaw;
         cx_ff[i]       <= cx_in;
         cy_ff[i]       <= cy_in;
         z_ff[i]        <= z_in;
         rem_ff[i]      <= rem_in;
         root_ff[i]     <= root_in;
         rad_ff[i]      <= rad_in;
         if (reset) begin
            tag_ff[i].valid <= 1'b0;
         end else begin
            tag_ff[i].valid <= tag_src.valid;
         end
      end
   end

   assign out_tag  = tag_ff[LEN-1];
   assign out_z    = z_ff[LEN-1];
   assign out_root = root_ff[LEN-1];

endmodule

`default_nettype wire

// ----- hdl/pbp_back.sv -----
// ----------------------------------------------------------------------------
// pbp_back
// Yaw correction, bin division, bin wrap and range offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbp_back import pbp_pkg::*; #(
   parameter int SCAN_BINS         = 898,
   parameter int WIDE_HALF_WIDTH   = 10,
   parameter int NARROW_HALF_WIDTH = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tag_type               in_tag,
   input  wire logic signed [Z_W-1:0] in_z,
   input  wire logic [15:0]           in_root,
   input  wire logic [7:0]            wide_range_offset,
   output logic                       rsp_strobe,
   output rsp_type                    rsp_data
);

   localparam int          MOD_SH    = 24;
   localparam logic [24:0] MOD_RECIP = 25'((1 << MOD_SH) / SCAN_BINS);
   localparam logic [13:0] NBINS     = 14'(SCAN_BINS);
   localparam logic [3:0]  HW_WIDE   = 4'(WIDE_HALF_WIDTH);
   localparam logic [3:0]  HW_NARROW = 4'(NARROW_HALF_WIDTH);

   // Stage 1: bearing relative to the heading, wrapped and shifted to [0, 2pi].
   logic                    s1_valid_ff, s1_keep_ff;
   logic [26:0]             s1_ang_ff;
   logic [15:0]             s1_range_ff;
   logic [3:0]              s1_hw_ff;
   logic signed [ANG_W-1:0] a0, a1, a2, a3;
   logic [15:0]             range_in;
   logic [3:0]              hw_in;

   always_comb begin
      a0 = ANG_W'(in_z) - (ANG_W'(in_tag.yaw) <<< 11);
      a1 = (a0 < -ANG_PI) ? a0 + ANG_TWOPI : a0;
      a2 = (a1 > ANG_PI) ? a1 - ANG_TWOPI : a1;
      a3 = a2 + ANG_PI;
      if (a3 < 0) begin
         a3 = '0;
      end
      unique case (in_tag.kind)
         KIND_WIDE: begin
            hw_in    = HW_WIDE;
            range_in = (in_root > 16'(wide_range_offset))
                     ? in_root - 16'(wide_range_offset) : 16'd0;
         end
         KIND_NARROW: begin
            hw_in    = HW_NARROW;
            range_in = in_root;
         end
         default: begin
            hw_in    = 4'd0;
            range_in = in_root;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s1_ang_ff   <= a3[26:0];
      s1_range_ff <= range_in;
      s1_hw_ff    <= hw_in;
      s1_keep_ff  <= in_tag.keep;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_tag.valid;
      end
   end

   // Stage 2: scale by 1000 / 2^24.
   logic        s2_valid_ff, s2_keep_ff;
   logic [12:0] s2_q_ff;
   logic [15:0] s2_range_ff;
   logic [3:0]  s2_hw_ff;
   logic [36:0] scaled;

   assign scaled = 37'(s1_ang_ff) * 37'(BIN_NUM);

   always_ff @(posedge clock) begin
      s2_q_ff     <= scaled[BIN_SHIFT +: 13];
      s2_range_ff <= s1_range_ff;
      s2_hw_ff    <= s1_hw_ff;
      s2_keep_ff  <= s1_keep_ff;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage 3: quotient estimate for the division by seven.
   logic        s3_valid_ff, s3_keep_ff;
   logic [12:0] s3_q_ff;
   logic [10:0] s3_qe_ff;
   logic [15:0] s3_range_ff;
   logic [3:0]  s3_hw_ff;
   logic [26:0] p7;

   assign p7 = 27'(s2_q_ff) * 27'(RECIP7);

   always_ff @(posedge clock) begin
      s3_qe_ff    <= p7[RECIP7_SH +: 11];
      s3_q_ff     <= s2_q_ff;
      s3_range_ff <= s2_range_ff;
      s3_hw_ff    <= s2_hw_ff;
      s3_keep_ff  <= s2_keep_ff;
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 4: the estimate is low by at most one.
   logic        s4_valid_ff, s4_keep_ff;
   logic [10:0] s4_bin_ff;
   logic [15:0] s4_range_ff;
   logic [3:0]  s4_hw_ff;
   logic [12:0] r7;

   assign r7 = s3_q_ff - ((13'(s3_qe_ff) << 3) - 13'(s3_qe_ff));

   always_ff @(posedge clock) begin
      s4_bin_ff   <= (r7 >= 13'd7) ? s3_qe_ff + 11'd1 : s3_qe_ff;
      s4_range_ff <= s3_range_ff;
      s4_hw_ff    <= s3_hw_ff;
      s4_keep_ff  <= s3_keep_ff;
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 5: quotient estimate for the wrap by the bin count.
   logic        s5_valid_ff, s5_keep_ff;
   logic [10:0] s5_bin_ff;
   logic [11:0] s5_qm_ff;
   logic [15:0] s5_range_ff;
   logic [3:0]  s5_hw_ff;
   logic [35:0] pm;

   assign pm = 36'(s4_bin_ff) * 36'(MOD_RECIP);

   always_ff @(posedge clock) begin
      s5_qm_ff    <= pm[MOD_SH +: 12];
      s5_bin_ff   <= s4_bin_ff;
      s5_range_ff <= s4_range_ff;
      s5_hw_ff    <= s4_hw_ff;
      s5_keep_ff  <= s4_keep_ff;
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 6: remainder and result register. A dropped point reads all zero.
   logic [25:0] qn;
   logic [13:0] rm, rm_fix;
   logic        rsp_strobe_ff;
   rsp_type     rsp_data_ff;

   always_comb begin
      qn     = 26'(s5_qm_ff) * 26'(NBINS);
      rm     = 14'(s5_bin_ff) - qn[13:0];
      rm_fix = (rm >= NBINS) ? rm - NBINS : rm;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.hit         <= s5_keep_ff;
      rsp_data_ff.center_bin  <= s5_keep_ff ? rm_fix[9:0] : 10'd0;
      rsp_data_ff.half_width  <= s5_keep_ff ? s5_hw_ff : 4'd0;
      rsp_data_ff.range_value <= s5_keep_ff ? s5_range_ff : 16'd0;
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s5_valid_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hdl/point_to_scan_bin_projector.sv -----
// ----------------------------------------------------------------------------
// point_to_scan_bin_projector
// Projects one obstacle point per item onto a laser scan bin.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle while busy is low and returns
// one result item per input item, in order, after it has passed three front
// stages, one stage per CORDIC step or square root step, and six back stages
// for the yaw, the bin division and the bin wrap. The result sits on rsp_data
// for exactly the one cycle that rsp_strobe is high; the receiver must take it
// then. busy is high only in reset and the cycle after it.
`timescale 1ns / 1ps
`default_nettype none

module point_to_scan_bin_projector import pbp_pkg::*; #(
   parameter int SCAN_BINS         = 898,
   parameter int WIDE_HALF_WIDTH   = 10,
   parameter int NARROW_HALF_WIDTH = 1,
   parameter int CORDIC_STAGES     = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic        busy_ff;
   logic        service_enable_ff;
   logic [15:0] service_radius_sq_ff;
   logic [15:0] block_radius_sq_ff;
   logic [7:0]  wide_range_offset_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         service_enable_ff    <= 1'b1;
         service_radius_sq_ff <= 16'd200;
         block_radius_sq_ff   <= 16'd5000;
         wide_range_offset_ff <= 8'd13;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SERVICE_ENABLE:    service_enable_ff    <= csr_wdata[0];
            REG_SERVICE_RADIUS_SQ: service_radius_sq_ff <= csr_wdata;
            REG_BLOCK_RADIUS_SQ:   block_radius_sq_ff   <= csr_wdata;
            REG_WIDE_RANGE_OFFSET: wide_range_offset_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign busy = busy_ff;

   tag_type                front_tag, iter_tag;
   logic signed [CX_W-1:0] front_cx, front_cy;
   logic signed [Z_W-1:0]  front_z, iter_z;
   logic [31:0]            front_rad;
   logic [15:0]            iter_root;

   pbp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (start && !busy_ff),
      .req               (req_data),
      .service_enable    (service_enable_ff),
      .service_radius_sq (service_radius_sq_ff),
      .block_radius_sq   (block_radius_sq_ff),
      .out_tag           (front_tag),
      .out_cx            (front_cx),
      .out_cy            (front_cy),
      .out_z             (front_z),
      .out_rad           (front_rad)
   );

   pbp_iter #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_iter (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (front_tag),
      .in_cx    (front_cx),
      .in_cy    (front_cy),
      .in_z     (front_z),
      .in_rad   (front_rad),
      .out_tag  (iter_tag),
      .out_z    (iter_z),
      .out_root (iter_root)
   );

   pbp_back #(
      .SCAN_BINS         (SCAN_BINS),
      .WIDE_HALF_WIDTH   (WIDE_HALF_WIDTH),
      .NARROW_HALF_WIDTH (NARROW_HALF_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .in_tag            (iter_tag),
      .in_z              (iter_z),
      .in_root           (iter_root),
      .wide_range_offset (wide_range_offset_ff),
      .rsp_strobe        (rsp_strobe),
      .rsp_data          (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hdl/pbp_checker.sv -----
// ----------------------------------------------------------------------------
// pbp_checker
// Port level checks of the projector, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "point_to_scan_bin_projector_defines.svh"

module pbp_checker import pbp_pkg::*; #(
   parameter int SCAN_BINS         = 898,
   parameter int WIDE_HALF_WIDTH   = 10,
   parameter int NARROW_HALF_WIDTH = 1
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   // A dropped point carries no bin, width or range.
   `PBP_ASSERT(a_drop_zero, rsp_strobe && !rsp_data.hit |-> rsp_data.center_bin == 10'd0 && rsp_data.half_width == 4'd0 && rsp_data.range_value == 16'd0, "dropped item has nonzero fields")

   // A kept point lands inside the scan.
   `PBP_ASSERT(a_bin_range, rsp_strobe && rsp_data.hit |-> 32'(rsp_data.center_bin) < SCAN_BINS, "bin beyond scan")

   // The half-width is one of the three kind widths.
   `PBP_ASSERT(a_half_width, rsp_strobe && rsp_data.hit |-> rsp_data.half_width == 4'd0 || rsp_data.half_width == 4'(NARROW_HALF_WIDTH) || rsp_data.half_width == 4'(WIDE_HALF_WIDTH), "unexpected half-width")

   // Reset flushes every item in flight.
   `PBP_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_strobe, "result after reset")

endmodule

bind point_to_scan_bin_projector pbp_checker #(
   .SCAN_BINS         (SCAN_BINS),
   .WIDE_HALF_WIDTH   (WIDE_HALF_WIDTH),
   .NARROW_HALF_WIDTH (NARROW_HALF_WIDTH)
) u_pbp_checker (.*);

`default_nettype wire
